### sv/link_header_walker_unit_macros.svh
// Assertion macros for the link header walker unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LINK_HEADER_WALKER_UNIT_MACROS_SVH
`define LINK_HEADER_WALKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LHW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LHW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LHW_ASSERT(lbl, clk, rst, prop, msg)
`define LHW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/lhw_pkg.sv
// Shared types and constants of the link header walker.
// No dependencies.
`timescale 1ns / 1ps
package lhw_pkg;
   typedef enum logic [6:0] {
      PH_ETH     = 7'b0000001,
      PH_VLAN    = 7'b0000010,
      PH_PPPOE   = 7'b0000100,
      PH_MPLS    = 7'b0001000,
      PH_MPLS_IP = 7'b0010000,
      PH_DONE    = 7'b0100000,
      PH_FAIL    = 7'b1000000
   } phase_type;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TRUNC_FAB   = 3'd1;
   localparam logic [2:0] ST_TRUNC       = 3'd2;
   localparam logic [2:0] ST_PPPOE_NONIP = 3'd3;
   localparam logic [2:0] ST_ETH_NONIP   = 3'd4;
   localparam logic [2:0] ST_MPLS_NOIP   = 3'd5;

   localparam logic [1:0] L3_NONE    = 2'd0;
   localparam logic [1:0] L3_IPV4    = 2'd1;
   localparam logic [1:0] L3_IPV6    = 2'd2;
   localparam logic [1:0] L3_ARP     = 2'd3;

   localparam logic [15:0] ET_FABRIC = 16'h8903;
   localparam logic [15:0] ET_VLAN   = 16'h8100;
   localparam logic [15:0] ET_QINQ   = 16'h9100;
   localparam logic [15:0] ET_PPPOE  = 16'h8864;
   localparam logic [15:0] ET_MPLS   = 16'h8847;
   localparam logic [15:0] ET_IPV4   = 16'h0800;
   localparam logic [15:0] ET_IPV6   = 16'h86dd;
   localparam logic [15:0] ET_ARP    = 16'h0806;
   localparam logic [15:0] ET_RARP   = 16'h8035;
   localparam logic [15:0] PPP_IPV4  = 16'h0021;
   localparam logic [15:0] PPP_IPV6  = 16'h0057;

   localparam logic [13:0] HSIZE_MAX = 14'h3fff;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] proto;
      logic [15:0] etype;
      logic [11:0] outer_vlan;
      logic [11:0] vlan_inner;
      logic [1:0]  l3;
      logic [13:0] base;
      logic [13:0] hend;
      logic [4:0]  mac;
   } rec_type;
endpackage

### sv/lhw_if.sv
// Handshake channels of the link header walker: frame bytes in, frame summaries out.
// No dependencies.
`timescale 1ns / 1ps
interface lhw_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [13:0] start_offset;
   modport source (output valid, data_byte, last_byte, start_offset, input ready);
   modport sink (input valid, data_byte, last_byte, start_offset, output ready);
endinterface

interface lhw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] next_protocol;
   logic [15:0] ether_type;
   logic [11:0] outer_vlan_id;
   logic [11:0] inner_vlan_id;
   logic [1:0]  l3_class;
   logic [13:0] header_size;
   logic [4:0]  mac_offset;
   modport source (output valid, status, next_protocol, ether_type, outer_vlan_id,
                   inner_vlan_id, l3_class, header_size, mac_offset, input ready);
   modport sink (input valid, status, next_protocol, ether_type, outer_vlan_id,
                 inner_vlan_id, l3_class, header_size, mac_offset, output ready);
endinterface

### sv/link_header_walker_unit.sv
// Link header walker: takes a frame one byte per beat (last_byte marks the end) and
// gives one summary beat per frame: status, final protocol, ethertype, VLAN ids,
// L3 class, header size and MAC offset. It accepts one byte every cycle while the
// queue is not full; a summary beat is offered once the last byte is taken: the
// summary is written into the two-entry queue and then loaded into the result register.
// The input stalls only when the queue is full because the result side is backed up.
`timescale 1ns / 1ps
module link_header_walker_unit import lhw_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 16384
) (
   input  logic      clock,
   input  logic      reset,
   lhw_req_if.sink   req_bus,
   lhw_rsp_if.source rsp_bus
);
   logic    push, pop, q_full, q_empty;
   rec_type push_rec, pop_rec;

   lhw_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
      .clock(clock), .reset(reset), .req_bus(req_bus),
      .q_full(q_full), .push(push), .push_rec(push_rec)
   );

   lhw_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_rec(push_rec),
      .pop(pop), .pop_rec(pop_rec), .full(q_full), .empty(q_empty)
   );

   lhw_back u_back (
      .clock(clock), .reset(reset), .pop_rec(pop_rec), .empty(q_empty),
      .pop(pop), .rsp_bus(rsp_bus)
   );
endmodule

### sv/lhw_front.sv
// Front end: takes frame beats, walks the link headers, emits one summary per frame.
// Depends on lhw_pkg and lhw_req_if.
`timescale 1ns / 1ps
module lhw_front import lhw_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 16384
) (
   input  logic       clock,
   input  logic       reset,
   lhw_req_if.sink    req_bus,
   input  logic       q_full,
   output logic       push,
   output rec_type    push_rec
);
   localparam int IDXW = $clog2(MAX_FRAME_BYTES);
   localparam int HW = IDXW + 1;
   localparam int EW = (HW > 14) ? HW : 15;
   localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_FRAME_BYTES - 1);

   logic [IDXW-1:0] idx_ff, idx_in;
   logic            full_ff, full_in;
   phase_type       phase_ff, phase_in;
   logic [HW-1:0]   hend_ff, hend_in;
   logic [13:0]     base_ff, base_in;
   logic [15:0]     tacc_ff, tacc_in;
   logic [15:0]     proto_ff, proto_in;
   logic [15:0]     eth_ff, eth_in;
   logic [11:0]     outer_ff, outer_in;
   logic [11:0]     inner_ff, inner_in;
   logic [11:0]     pend_ff, pend_in;
   logic            seen_ff, seen_in;
   logic [1:0]      l3_ff, l3_in;
   logic [4:0]      mac_ff, mac_in;
   logic [2:0]      fail_ff, fail_in;
   logic            bos_ff, bos_in;
   logic [3:0]      ipv_ff, ipv_in;

   logic            accept;
   logic            enter;
   logic [HW-1:0]   iw, start, off, p;
   logic [15:0]     t;
   logic [7:0]      b;
   logic            last;
   logic [2:0]      st;
   logic [EW-1:0]   hx;

   assign req_bus.ready = ~q_full;
   assign accept = req_bus.valid & req_bus.ready;
   assign b = req_bus.data_byte;
   assign last = req_bus.last_byte;

   always_comb begin
      idx_in = idx_ff; full_in = full_ff; phase_in = phase_ff; hend_in = hend_ff;
      base_in = base_ff; tacc_in = tacc_ff; proto_in = proto_ff; eth_in = eth_ff;
      outer_in = outer_ff; inner_in = inner_ff; pend_in = pend_ff; seen_in = seen_ff;
      l3_in = l3_ff; mac_in = mac_ff; fail_in = fail_ff; bos_in = bos_ff; ipv_in = ipv_ff;
      enter = 1'b0; t = '0; st = ST_OK; hx = '0; push = 1'b0; push_rec = '0;
      iw = HW'(idx_ff);
      start = hend_ff - HW'(14);
      off = '0;
      p = hend_ff;
      if (accept) begin
         if (idx_ff == '0 && !full_ff) begin
            base_in = req_bus.start_offset;
         end
         if (!full_ff) begin
            unique case (phase_ff)
               PH_ETH: begin
                  if (iw == start + HW'(12)) begin
                     tacc_in = {b, 8'h00};
                  end
                  if (iw == start + HW'(13)) begin
                     t = {tacc_ff[15:8], b};
                     tacc_in = t;
                     if (!(last && start != '0)) begin
                        if (start == '0 && t == ET_FABRIC) begin
                           hend_in = HW'(30);
                        end else begin
                           eth_in = t;
                           proto_in = t;
                           mac_in = start[4:0];
                           enter = 1'b1;
                        end
                     end
                  end
               end
               PH_VLAN: begin
                  off = iw - (hend_ff - HW'(4));
                  if (!last) begin
                     if (off == HW'(0)) begin
                        pend_in = {b[3:0], 8'h00};
                     end else if (off == HW'(1)) begin
                        pend_in = {pend_ff[11:8], b};
                     end else if (off == HW'(2)) begin
                        tacc_in = {b, 8'h00};
                     end else if (off == HW'(3)) begin
                        t = {tacc_ff[15:8], b};
                        tacc_in = t;
                        if (seen_ff) inner_in = pend_ff;
                        else outer_in = pend_ff;
                        seen_in = 1'b1;
                        proto_in = t;
                        eth_in = t;
                        enter = 1'b1;
                     end
                  end
               end
               PH_PPPOE: begin
                  off = iw - (hend_ff - HW'(8));
                  if (!last) begin
                     if (off == HW'(6)) begin
                        tacc_in = {b, 8'h00};
                     end else if (off == HW'(7)) begin
                        t = {tacc_ff[15:8], b};
                        tacc_in = t;
                        proto_in = t;
                        if (t == PPP_IPV4) begin
                           l3_in = L3_IPV4;
                           enter = 1'b1;
                        end else if (t == PPP_IPV6) begin
                           l3_in = L3_IPV6;
                           enter = 1'b1;
                        end else begin
                           phase_in = PH_FAIL;
                           fail_in = ST_PPPOE_NONIP;
                        end
                     end
                  end
               end
               PH_MPLS: begin
                  off = iw - (hend_ff - HW'(4));
                  if (!last) begin
                     if (off == HW'(2)) begin
                        bos_in = b[0];
                     end else if (off == HW'(3)) begin
                        if (bos_ff) begin
                           phase_in = PH_MPLS_IP;
                           hend_in = hend_ff + HW'(20);
                        end else begin
                           hend_in = hend_ff + HW'(4);
                        end
                     end
                  end
               end
               PH_MPLS_IP: begin
                  off = iw - (hend_ff - HW'(20));
                  if (!last) begin
                     if (off == HW'(0)) begin
                        ipv_in = b[7:4];
                     end else if (off == HW'(19)) begin
                        if (ipv_ff == 4'd4) begin
                           l3_in = L3_IPV4;
                           phase_in = PH_DONE;
                           hend_in = hend_ff - HW'(20);
                        end else if (ipv_ff == 4'd6) begin
                           l3_in = L3_IPV6;
                           phase_in = PH_DONE;
                           hend_in = hend_ff - HW'(20);
                        end else begin
                           phase_in = PH_FAIL;
                           fail_in = ST_MPLS_NOIP;
                        end
                     end
                  end
               end
               PH_DONE, PH_FAIL: begin
               end
               default: begin
               end
            endcase
            if (enter) begin
               p = hend_in;
               if (proto_in == ET_VLAN || proto_in == ET_QINQ) begin
                  phase_in = PH_VLAN;
                  hend_in = p + HW'(4);
               end else if (proto_in == ET_PPPOE) begin
                  phase_in = PH_PPPOE;
                  hend_in = p + HW'(8);
               end else if (proto_in == ET_MPLS) begin
                  phase_in = PH_MPLS;
                  hend_in = p + HW'(4);
               end else begin
                  phase_in = PH_DONE;
                  hend_in = p;
                  if (l3_in == L3_NONE) begin
                     if (proto_in == ET_IPV4) l3_in = L3_IPV4;
                     else if (proto_in == ET_IPV6) l3_in = L3_IPV6;
                     else if (proto_in == ET_ARP || proto_in == ET_RARP) l3_in = L3_ARP;
                     else begin
                        phase_in = PH_FAIL;
                        fail_in = ST_ETH_NONIP;
                        hend_in = hend_ff;
                     end
                  end
               end
            end
         end
         if (idx_ff != IDX_LAST) idx_in = idx_ff + IDXW'(1);
         else full_in = 1'b1;

         if (last) begin
            unique case (phase_in)
               PH_ETH: st = (hend_in == HW'(30)) ? ST_TRUNC_FAB : ST_TRUNC;
               PH_VLAN, PH_PPPOE, PH_MPLS: st = ST_TRUNC;
               PH_MPLS_IP: st = ST_MPLS_NOIP;
               PH_DONE: st = ST_OK;
               PH_FAIL: st = fail_in;
               default: st = fail_in;
            endcase
            hx = EW'(hend_in);
            push = 1'b1;
            push_rec.status = st;
            push_rec.proto = proto_in;
            push_rec.etype = eth_in;
            push_rec.outer_vlan = outer_in;
            push_rec.vlan_inner = inner_in;
            push_rec.l3 = l3_in;
            push_rec.base = base_in;
            push_rec.hend = (hx > EW'(HSIZE_MAX)) ? HSIZE_MAX : hx[13:0];
            push_rec.mac = mac_in;
            idx_in = '0; full_in = 1'b0; phase_in = PH_ETH; hend_in = HW'(14);
            base_in = '0; tacc_in = '0; proto_in = '0; eth_in = '0;
            outer_in = '0; inner_in = '0; pend_in = '0; seen_in = 1'b0;
            l3_in = L3_NONE; mac_in = '0; fail_in = ST_OK; bos_in = 1'b0; ipv_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0; full_ff <= 1'b0; phase_ff <= PH_ETH; hend_ff <= HW'(14);
         base_ff <= '0; tacc_ff <= '0; proto_ff <= '0; eth_ff <= '0;
         outer_ff <= '0; inner_ff <= '0; pend_ff <= '0; seen_ff <= 1'b0;
         l3_ff <= L3_NONE; mac_ff <= '0; fail_ff <= ST_OK; bos_ff <= 1'b0; ipv_ff <= '0;
      end else begin
         idx_ff <= idx_in; full_ff <= full_in; phase_ff <= phase_in; hend_ff <= hend_in;
         base_ff <= base_in; tacc_ff <= tacc_in; proto_ff <= proto_in; eth_ff <= eth_in;
         outer_ff <= outer_in; inner_ff <= inner_in; pend_ff <= pend_in; seen_ff <= seen_in;
         l3_ff <= l3_in; mac_ff <= mac_in; fail_ff <= fail_in; bos_ff <= bos_in;
         ipv_ff <= ipv_in;
      end
   end
endmodule

### sv/lhw_queue.sv
// Two-entry summary queue between the header walker front end and the result stage.
// Depends on lhw_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "link_header_walker_unit_macros.svh"
module lhw_queue import lhw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output rec_type pop_rec,
   output logic    full,
   output logic    empty
);
   rec_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign pop_rec = mem_ff[rd_ff];
   assign wr_in = push ? ~wr_ff : wr_ff;
   assign rd_in = pop ? ~rd_ff : rd_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   `LHW_ASSERT(a_no_overflow, clock, reset, push |-> !full, "push into full queue")
   `LHW_ASSERT(a_no_underflow, clock, reset, pop |-> !empty, "pop from empty queue")
   `LHW_ASSERT(a_ptr_gap, clock, reset, (cnt_ff == 2'd1) |-> (wr_ff != rd_ff), "pointer skew")
   `LHW_ASSERT(a_cnt_range, clock, reset, cnt_ff != 2'd3, "queue count out of range")
endmodule

### sv/lhw_back.sv
// Result stage: finishes header size and failure zeroing, holds the result beat.
// Depends on lhw_pkg and lhw_rsp_if.
`timescale 1ns / 1ps
module lhw_back import lhw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  rec_type   pop_rec,
   input  logic      empty,
   output logic      pop,
   lhw_rsp_if.source rsp_bus
);
   logic        valid_ff, valid_in;
   logic [2:0]  st_ff;
   logic [15:0] proto_ff, eth_ff;
   logic [11:0] outer_ff, inner_ff;
   logic [1:0]  l3_ff;
   logic [13:0] hsize_ff, hsize_in;
   logic [4:0]  mac_ff;
   logic [14:0] sum;
   logic        ok;

   assign pop = !empty && (!valid_ff || rsp_bus.ready);
   assign sum = 15'(pop_rec.base) + 15'(pop_rec.hend);
   assign ok = (pop_rec.status == ST_OK);
   assign hsize_in = !ok ? 14'd0 : (sum > 15'(HSIZE_MAX)) ? HSIZE_MAX : sum[13:0];

   always_comb begin
      valid_in = valid_ff;
      if (rsp_bus.ready) valid_in = 1'b0;
      if (pop) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         st_ff <= pop_rec.status;
         proto_ff <= ok ? pop_rec.proto : 16'd0;
         eth_ff <= pop_rec.etype;
         outer_ff <= pop_rec.outer_vlan;
         inner_ff <= pop_rec.vlan_inner;
         l3_ff <= pop_rec.l3;
         hsize_ff <= hsize_in;
         mac_ff <= pop_rec.mac;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.status = st_ff;
   assign rsp_bus.next_protocol = proto_ff;
   assign rsp_bus.ether_type = eth_ff;
   assign rsp_bus.outer_vlan_id = outer_ff;
   assign rsp_bus.inner_vlan_id = inner_ff;
   assign rsp_bus.l3_class = l3_ff;
   assign rsp_bus.header_size = hsize_ff;
   assign rsp_bus.mac_offset = mac_ff;
endmodule
